### hdl/sbme_pkg.sv
package sbme_pkg;

  localparam int CMD_W  = 4;
  localparam int REG_W  = 4;
  localparam int BYTE_W = 8;
  localparam int ADDR_W = 8;

  localparam int NUM_REGS  = 16;
  localparam int MEM_DEPTH = 256;

  localparam logic [CMD_W-1:0] OP_LOAD_MEM = 4'h1;
  localparam logic [CMD_W-1:0] OP_LOAD_IMM = 4'h2;
  localparam logic [CMD_W-1:0] OP_STORE    = 4'h3;
  localparam logic [CMD_W-1:0] OP_MOVE     = 4'h4;
  localparam logic [CMD_W-1:0] OP_ADD      = 4'h5;
  localparam logic [CMD_W-1:0] OP_HALT     = 4'hC;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [REG_W-1:0]  reg_r;
    logic [BYTE_W-1:0] operand_byte;
  } instr_t;

  typedef struct packed {
    logic              executed;
    logic              halted;
    logic              reg_write_valid;
    logic [REG_W-1:0]  reg_write_index;
    logic [BYTE_W-1:0] write_data;
    logic              mem_write_valid;
    logic [ADDR_W-1:0] mem_write_address;
  } result_t;

endpackage

### hdl/sbme_in_if.sv
interface sbme_in_if;
  logic                        valid;
  logic                        ready;
  logic [sbme_pkg::CMD_W-1:0]  cmd;
  logic [sbme_pkg::REG_W-1:0]  reg_r;
  logic [sbme_pkg::BYTE_W-1:0] operand_byte;

  modport source (output valid, cmd, reg_r, operand_byte, input ready);
  modport sink   (input valid, cmd, reg_r, operand_byte, output ready);
endinterface

### hdl/sbme_out_if.sv
interface sbme_out_if;
  logic                        valid;
  logic                        ready;
  logic                        executed;
  logic                        halted;
  logic                        reg_write_valid;
  logic [sbme_pkg::REG_W-1:0]  reg_write_index;
  logic [sbme_pkg::BYTE_W-1:0] write_data;
  logic                        mem_write_valid;
  logic [sbme_pkg::ADDR_W-1:0] mem_write_address;

  modport source (output valid, executed, halted, reg_write_valid, reg_write_index,
                  write_data, mem_write_valid, mem_write_address, input ready);
  modport sink   (input valid, executed, halted, reg_write_valid, reg_write_index,
                  write_data, mem_write_valid, mem_write_address, output ready);
endinterface

### hdl/sbme_ram.sv
module sbme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/sbme_exec.sv
module sbme_exec (
  input  sbme_pkg::instr_t              instr_i,
  input  logic                          halt_i,
  input  logic [sbme_pkg::BYTE_W-1:0]   rf_a_i,
  input  logic [sbme_pkg::BYTE_W-1:0]   rf_b_i,
  input  logic [sbme_pkg::BYTE_W-1:0]   mem_i,
  input  logic [sbme_pkg::ADDR_W-1:0]   mem_addr_i,
  output sbme_pkg::result_t             res_o
);

  always_comb begin
    res_o        = '0;
    res_o.halted = halt_i;
    if (!halt_i) begin
      case (instr_i.cmd)
        sbme_pkg::OP_LOAD_MEM: begin
          res_o.executed        = 1'b1;
          res_o.reg_write_valid = 1'b1;
          res_o.reg_write_index = instr_i.reg_r;
          res_o.write_data      = mem_i;
        end
        sbme_pkg::OP_LOAD_IMM: begin
          res_o.executed        = 1'b1;
          res_o.reg_write_valid = 1'b1;
          res_o.reg_write_index = instr_i.reg_r;
          res_o.write_data      = instr_i.operand_byte;
        end
        sbme_pkg::OP_STORE: begin
          res_o.executed          = 1'b1;
          res_o.mem_write_valid   = 1'b1;
          res_o.mem_write_address = mem_addr_i;
          res_o.write_data        = rf_a_i;
        end
        sbme_pkg::OP_MOVE: begin
          res_o.executed        = 1'b1;
          res_o.reg_write_valid = 1'b1;
          res_o.reg_write_index = instr_i.operand_byte[sbme_pkg::REG_W-1:0];
          res_o.write_data      = rf_a_i;
        end
        sbme_pkg::OP_ADD: begin
          res_o.executed        = 1'b1;
          res_o.reg_write_valid = 1'b1;
          res_o.reg_write_index = instr_i.reg_r;
          res_o.write_data      = rf_a_i + rf_b_i;
        end
        sbme_pkg::OP_HALT: begin
          res_o.executed = 1'b1;
          res_o.halted   = 1'b1;
        end
        default: begin
          res_o.executed = 1'b0;
        end
      endcase
    end
  end

endmodule

### hdl/simple_byte_machine_executor_core.sv
// Channel | Dir | Handshake    | Payload
// in_ch   | in  | valid/ready  | cmd, reg_r, operand_byte
// out_ch  | out | valid/ready  | executed, halted, reg_write_valid, reg_write_index,
//         |     |              | write_data, mem_write_valid, mem_write_address
//
// One item per cycle sustained while out_ch is ready; results pass the execute stage, then the output register.
// Register file and data memory reads are issued on acceptance (registered RAM read),
// execution and write-back happen as the item moves into the output register.
// Reset is synchronous; per-entry valid bits make both stores read as zero at once.
// A stalled output holds the execute stage; input is still taken while a slot frees.
module simple_byte_machine_executor_core #(
  parameter int MEM_DEPTH = sbme_pkg::MEM_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  sbme_in_if.sink        in_ch,
  sbme_out_if.source     out_ch
);

  localparam int MEM_AW = $clog2(MEM_DEPTH);
  localparam int RF_AW  = $clog2(sbme_pkg::NUM_REGS);

  // address wrap table, built at elaboration
  logic [MEM_AW-1:0] wrap_tbl [2**sbme_pkg::ADDR_W];
  for (genvar i = 0; i < 2**sbme_pkg::ADDR_W; i++) begin : g_wrap
    assign wrap_tbl[i] = MEM_AW'(i % MEM_DEPTH);
  end

  logic                  in_fire;
  logic                  s1_fire;
  logic                  s1_v_r;
  sbme_pkg::instr_t      s1_instr_r;
  logic [MEM_AW-1:0]     s1_maddr_r;
  logic                  a_byp_r, b_byp_r, m_byp_r;
  logic                  a_vld_r, b_vld_r, m_vld_r;
  logic [sbme_pkg::BYTE_W-1:0] byp_data_r;
  logic                  halt_r;
  logic                  out_v_r;
  sbme_pkg::result_t     out_r;
  logic [sbme_pkg::NUM_REGS-1:0] rf_vld_r;
  logic [MEM_DEPTH-1:0]  mem_vld_r;

  sbme_pkg::instr_t      in_instr;
  logic [RF_AW-1:0]      rd_a_addr, rd_b_addr;
  logic [MEM_AW-1:0]     rd_m_addr;
  logic [sbme_pkg::BYTE_W-1:0] rf_a_q, rf_b_q, mem_q;
  logic [sbme_pkg::BYTE_W-1:0] rf_a, rf_b, mem_d;
  sbme_pkg::result_t     res;
  logic                  rf_we, mem_we;
  logic [RF_AW-1:0]      rf_waddr;

  assign in_instr.cmd          = in_ch.cmd;
  assign in_instr.reg_r        = in_ch.reg_r;
  assign in_instr.operand_byte = in_ch.operand_byte;

  assign s1_fire     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign rd_a_addr = (in_ch.cmd == sbme_pkg::OP_STORE) ? in_ch.reg_r
                                                       : in_ch.operand_byte[7:4];
  assign rd_b_addr = in_ch.operand_byte[3:0];
  assign rd_m_addr = wrap_tbl[in_ch.operand_byte];

  assign rf_we    = s1_fire && res.reg_write_valid;
  assign mem_we   = s1_fire && res.mem_write_valid;
  assign rf_waddr = res.reg_write_index;

  sbme_ram #(.WIDTH(sbme_pkg::BYTE_W), .DEPTH(sbme_pkg::NUM_REGS)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (res.write_data),
    .re    (in_fire),
    .raddr (rd_a_addr),
    .rdata (rf_a_q)
  );

  sbme_ram #(.WIDTH(sbme_pkg::BYTE_W), .DEPTH(sbme_pkg::NUM_REGS)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (res.write_data),
    .re    (in_fire),
    .raddr (rd_b_addr),
    .rdata (rf_b_q)
  );

  sbme_ram #(.WIDTH(sbme_pkg::BYTE_W), .DEPTH(MEM_DEPTH)) u_dmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_maddr_r),
    .wdata (res.write_data),
    .re    (in_fire),
    .raddr (rd_m_addr),
    .rdata (mem_q)
  );

  // forwarded write beats the RAM, unwritten entries read as zero
  assign rf_a  = a_byp_r ? byp_data_r : (a_vld_r ? rf_a_q : '0);
  assign rf_b  = b_byp_r ? byp_data_r : (b_vld_r ? rf_b_q : '0);
  assign mem_d = m_byp_r ? byp_data_r : (m_vld_r ? mem_q : '0);

  sbme_exec u_exec (
    .instr_i    (s1_instr_r),
    .halt_i     (halt_r),
    .rf_a_i     (rf_a),
    .rf_b_i     (rf_b),
    .mem_i      (mem_d),
    .mem_addr_i (sbme_pkg::ADDR_W'(s1_maddr_r)),
    .res_o      (res)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr_r <= in_instr;
      s1_maddr_r <= rd_m_addr;
      a_byp_r    <= rf_we && (rf_waddr == rd_a_addr);
      b_byp_r    <= rf_we && (rf_waddr == rd_b_addr);
      m_byp_r    <= mem_we && (s1_maddr_r == rd_m_addr);
      a_vld_r    <= rf_vld_r[rd_a_addr];
      b_vld_r    <= rf_vld_r[rd_b_addr];
      m_vld_r    <= mem_vld_r[rd_m_addr];
      byp_data_r <= res.write_data;
    end
    if (s1_fire) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      halt_r    <= 1'b0;
      rf_vld_r  <= '0;
      mem_vld_r <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (s1_fire) begin
        out_v_r <= 1'b1;
        halt_r  <= res.halted;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (rf_we) begin
        rf_vld_r[rf_waddr] <= 1'b1;
      end
      if (mem_we) begin
        mem_vld_r[s1_maddr_r] <= 1'b1;
      end
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.executed          = out_r.executed;
  assign out_ch.halted            = out_r.halted;
  assign out_ch.reg_write_valid   = out_r.reg_write_valid;
  assign out_ch.reg_write_index   = out_r.reg_write_index;
  assign out_ch.write_data        = out_r.write_data;
  assign out_ch.mem_write_valid   = out_r.mem_write_valid;
  assign out_ch.mem_write_address = out_r.mem_write_address;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared without reset");

  a_no_write_halted: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> !rf_we && !mem_we)
    else $error("store written after halt");

  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(rf_we && mem_we))
    else $error("register and memory written by one item");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_fire |=> s1_v_r && $stable(s1_instr_r))
    else $error("execute stage lost a stalled item");

endmodule
